// ===== hw/rtl/sqr_pkg.sv =====
// sqr_pkg: shared constants and types for the slot queue with removal
// used by sqr_cell and slot_queue_with_removal_top, depends on nothing
package sqr_pkg;

  localparam int SLOT_COUNT = 5;
  localparam int CODE_W     = 16;
  localparam int REQ_W      = 3;
  localparam int IDX_W      = 3;
  localparam int OCC_OUT_W  = 3;
  localparam int OCC_W      = $clog2(SLOT_COUNT + 1);

  localparam logic [CODE_W-1:0] EMPTY_CODE = 16'd228;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [REQ_W-1:0] {
    OP_ENQUEUE = 3'd0,
    OP_REMOVE  = 3'd1,
    OP_ADVANCE = 3'd2,
    OP_CLEAR   = 3'd3,
    OP_PEEK    = 3'd4
  } req_op_t;

  // request broadcast to every cell of the chain
  typedef struct packed {
    logic              go;
    req_op_t           op;
    logic [CODE_W-1:0] code;
    logic              shift_en;
  } cell_req_t;

endpackage

// ===== hw/rtl/sqr_cell.sv =====
// sqr_cell: one queue slot, held in order relative to the head
// depends on sqr_pkg; chained in slot_queue_with_removal_top
module sqr_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  sqr_pkg::cell_req_t        req,
  input  logic                      at_or_after,
  input  logic                      free_in,
  input  logic [sqr_pkg::CODE_W-1:0] right_value,
  output logic                      free_out,
  output logic [sqr_pkg::CODE_W-1:0] value,
  output logic [sqr_pkg::CODE_W-1:0] value_next
);
  import sqr_pkg::*;

  logic is_free;

  assign is_free  = (value == EMPTY_CODE);
  // free slot seen at this cell or any cell nearer the head
  assign free_out = free_in | is_free;

  always_comb begin
    value_next = value;
    case (req.op)
      OP_ENQUEUE: begin
        if (is_free && !free_in) value_next = req.code;
      end
      OP_REMOVE, OP_ADVANCE: begin
        if (req.shift_en && at_or_after) value_next = right_value;
      end
      OP_CLEAR: begin
        value_next = EMPTY_CODE;
      end
      default: begin
        value_next = value;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= EMPTY_CODE;
    end else if (req.go) begin
      value <= value_next;
    end
  end

endmodule

// ===== hw/rtl/slot_queue_with_removal_top.sv =====
// slot_queue_with_removal_top: slot queue as a chain of cells kept in head order
// result: registered as the request is taken, held until it is read
// throughput: one request per cycle while the output register is empty or being read
// reset: rst synchronous, all slots read empty, output valid cleared
// depends on sqr_pkg and sqr_cell
module slot_queue_with_removal_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // req_type[2:0], item_code[18:3], slot_index[21:19], zero fill
  input  logic [sqr_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // ok[0], item_value[16:1], front_item[32:17], occupancy[35:33],
  // is_full[36], is_empty[37], zero fill
  output logic [sqr_pkg::OUT_DATA_W-1:0] m_tdata
);
  import sqr_pkg::*;

  req_op_t           op;
  logic [CODE_W-1:0] code;
  logic [IDX_W-1:0]  rel;
  logic              go;
  logic              rel_ok;
  logic [CODE_W-1:0] sel_value;
  logic              found;
  logic              head_busy;
  logic              ok;
  logic [CODE_W-1:0] item_value;
  logic [OCC_W-1:0]  count;
  cell_req_t         req;

  logic [CODE_W-1:0] cell_value [SLOT_COUNT];
  logic [CODE_W-1:0] cell_next  [SLOT_COUNT];
  logic [CODE_W-1:0] right_val  [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] at_or_after;
  logic [SLOT_COUNT:0]   free_chain;

  assign op   = req_op_t'(s_tdata[2:0]);
  assign code = s_tdata[18:3];
  assign rel  = s_tdata[21:19];

  assign s_tready = !m_tvalid || m_tready;
  assign go       = s_tvalid && s_tready;

  assign rel_ok = (32'(rel) < SLOT_COUNT);

  always_comb begin
    sel_value = EMPTY_CODE;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (rel_ok && (32'(rel) == i)) sel_value = cell_value[i];
    end
  end

  assign found     = (sel_value != EMPTY_CODE);
  assign head_busy = (cell_value[0] != EMPTY_CODE);

  assign req.go       = go;
  assign req.op       = op;
  assign req.code     = code;
  // advance is a removal at the head
  assign req.shift_en = ((op == OP_REMOVE) && found) || ((op == OP_ADVANCE) && head_busy);

  assign free_chain[0] = 1'b0;

  for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
    assign at_or_after[g] = (op == OP_ADVANCE) || (32'(rel) <= g);
    if (g == SLOT_COUNT - 1) begin : g_last
      assign right_val[g] = EMPTY_CODE;
    end else begin : g_mid
      assign right_val[g] = cell_value[g+1];
    end

    sqr_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .req         (req),
      .at_or_after (at_or_after[g]),
      .free_in     (free_chain[g]),
      .right_value (right_val[g]),
      .free_out    (free_chain[g+1]),
      .value       (cell_value[g]),
      .value_next  (cell_next[g])
    );
  end

  always_comb begin
    case (op)
      OP_ENQUEUE: ok = free_chain[SLOT_COUNT];
      OP_REMOVE:  ok = found;
      OP_ADVANCE: ok = head_busy;
      default:    ok = 1'b0;
    endcase
  end

  assign item_value = ((op == OP_REMOVE) || (op == OP_PEEK)) ? sel_value : EMPTY_CODE;

  always_comb begin
    count = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (cell_next[i] != EMPTY_CODE) count = count + OCC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      m_tdata <= {2'b00,
                  (count == OCC_W'(0)),
                  (32'(count) == SLOT_COUNT),
                  OCC_OUT_W'(count),
                  cell_next[0],
                  item_value,
                  ok};
    end
  end

endmodule

// ===== verif/slot_queue_with_removal_top_tb.sv =====
// slot_queue_with_removal_top_tb: stream-level test of the slot queue with removal
// a built-in queue predictor checks every result field; depends on sqr_pkg and the top level
`timescale 1ns / 100ps

module slot_queue_with_removal_top_tb;
  import sqr_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 650;

  // one result word, fields in port order
  typedef struct packed {
    logic              ok;
    logic [CODE_W-1:0] item_value;
    logic [CODE_W-1:0] front_item;
    logic [2:0]        occupancy;
    logic              is_full;
    logic              is_empty;
  } queue_status_t;

  class queue_scoreboard;
    logic [CODE_W-1:0] slot_codes[SLOT_COUNT];
    int unsigned       head_pos;
    queue_status_t     pending_results[$];
    int                errors;
    int                results_checked;

    function new();
      errors = 0;
      results_checked = 0;
      flush_slots();
    endfunction

    function void flush_slots();
      for (int i = 0; i < SLOT_COUNT; i++) slot_codes[i] = EMPTY_CODE;
      head_pos = 0;
    endfunction

    // apply one accepted request to the shadow queue and queue up its status
    function void note_request(logic [REQ_W-1:0] op, logic [CODE_W-1:0] code,
                               logic [IDX_W-1:0] idx);
      queue_status_t     st;
      logic [CODE_W-1:0] got;
      bit                placed;
      int                n;
      st = '0;
      st.item_value = EMPTY_CODE;
      placed = 0;
      case (op)
        OP_ENQUEUE: begin
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (!placed && slot_codes[(head_pos + i) % SLOT_COUNT] == EMPTY_CODE) begin
              slot_codes[(head_pos + i) % SLOT_COUNT] = code;
              placed = 1;
            end
          end
          st.ok = placed;
        end
        OP_REMOVE: begin
          if (idx < SLOT_COUNT) begin
            got = slot_codes[(head_pos + idx) % SLOT_COUNT];
            if (got != EMPTY_CODE) begin
              // later entries move up one place toward the head
              for (int i = idx; i + 1 < SLOT_COUNT; i++)
                slot_codes[(head_pos + i) % SLOT_COUNT] =
                  slot_codes[(head_pos + i + 1) % SLOT_COUNT];
              slot_codes[(head_pos + SLOT_COUNT - 1) % SLOT_COUNT] = EMPTY_CODE;
              st.item_value = got;
              st.ok = 1'b1;
            end
          end
        end
        OP_ADVANCE: begin
          if (slot_codes[head_pos] != EMPTY_CODE) begin
            slot_codes[head_pos] = EMPTY_CODE;
            head_pos = (head_pos + 1) % SLOT_COUNT;
            st.ok = 1'b1;
          end
        end
        OP_CLEAR: flush_slots();
        OP_PEEK: begin
          if (idx < SLOT_COUNT) st.item_value = slot_codes[(head_pos + idx) % SLOT_COUNT];
        end
        default: ;
      endcase
      n = 0;
      for (int i = 0; i < SLOT_COUNT; i++) if (slot_codes[i] != EMPTY_CODE) n++;
      st.front_item = slot_codes[head_pos];
      st.occupancy  = n[2:0];
      st.is_full    = (n == SLOT_COUNT);
      st.is_empty   = (n == 0);
      pending_results.push_back(st);
    endfunction

    function void compare_field(string label, logic [CODE_W-1:0] want,
                                logic [CODE_W-1:0] got);
      if (got !== want) begin
        $display("%0t mismatch on %s: expected %0h, actual %0h", $time, label, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] word);
      queue_status_t want;
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result %0h with no request outstanding", $time, word);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      results_checked++;
      compare_field("ok", want.ok, word[0]);
      compare_field("item_value", want.item_value, word[16:1]);
      compare_field("front_item", want.front_item, word[32:17]);
      compare_field("occupancy", want.occupancy, word[35:33]);
      compare_field("is_full", want.is_full, word[36]);
      compare_field("is_empty", want.is_empty, word[37]);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;

  queue_scoreboard board;
  bit              no_idle;
  int              op_count[8];
  int              cycles;

  slot_queue_with_removal_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               board.pending_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_request(logic [REQ_W-1:0] op, logic [CODE_W-1:0] code,
                              logic [IDX_W-1:0] idx);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    @(negedge clk);
    if (gap != 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  = {2'b00, idx, code, op};
    s_tvalid = 1'b1;
    do @(posedge clk); while (s_tready !== 1'b1);
    board.note_request(op, code, idx);
    op_count[op]++;
  endtask

  // receive side: random stall before each result unless no_idle is set
  initial begin
    int stall;
    wait (rst === 1'b0);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 6);
      @(negedge clk);
      if (stall != 0) begin
        m_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready = 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      board.check_result(m_tdata);
    end
  end

  initial begin
    int               r;
    logic [REQ_W-1:0] op;
    logic [CODE_W-1:0] code;
    logic [IDX_W-1:0] idx;
    board    = new();
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    m_tready = 1'b0;
    no_idle  = 0;
    cycles   = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty queue corner cases
    send_request(OP_PEEK, 16'h0000, 3'd0);
    send_request(OP_ADVANCE, 16'hffff, 3'd7);
    send_request(OP_REMOVE, 16'h0000, 3'd0);
    // fill up; the empty code is stored but leaves its slot free
    send_request(OP_ENQUEUE, 16'h0000, 3'd0);
    send_request(OP_ENQUEUE, 16'hffff, 3'd7);
    send_request(OP_ENQUEUE, 16'h1234, 3'd0);
    send_request(OP_ENQUEUE, EMPTY_CODE, 3'd0);
    send_request(OP_ENQUEUE, 16'habcd, 3'd0);
    send_request(OP_ENQUEUE, 16'h5555, 3'd0);
    send_request(OP_ENQUEUE, 16'haaaa, 3'd0);
    send_request(OP_PEEK, 16'h0000, 3'd4);
    send_request(OP_PEEK, 16'h0000, 3'd7);
    send_request(OP_REMOVE, 16'h0000, 3'd5);
    send_request(OP_REMOVE, 16'h0000, 3'd7);
    send_request(OP_REMOVE, 16'h0000, 3'd2);
    send_request(OP_REMOVE, 16'h0000, 3'd4);
    send_request(OP_ADVANCE, 16'h0000, 3'd0);
    send_request(OP_ADVANCE, 16'h0000, 3'd0);
    // enqueue at the tail, peek past the tail, then unused opcodes and clear
    send_request(OP_ENQUEUE, 16'h8001, 3'd0);
    send_request(OP_PEEK, 16'h0000, 3'd3);
    send_request(3'd5, 16'hffff, 3'd1);
    send_request(3'd6, 16'h0000, 3'd2);
    send_request(3'd7, 16'hffff, 3'd7);
    send_request(OP_CLEAR, 16'hffff, 3'd7);
    send_request(OP_ADVANCE, 16'h0000, 3'd0);

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if ($urandom_range(0, 40) == 0) no_idle = !no_idle;
      r = $urandom_range(0, 99);
      if (r < 38)      op = OP_ENQUEUE;
      else if (r < 58) op = OP_REMOVE;
      else if (r < 72) op = OP_ADVANCE;
      else if (r < 91) op = OP_PEEK;
      else if (r < 94) op = OP_CLEAR;
      else             op = 3'($urandom_range(5, 7));
      r = $urandom_range(0, 19);
      if (r == 0)      code = EMPTY_CODE;
      else if (r == 1) code = 16'h0000;
      else if (r == 2) code = 16'hffff;
      else             code = 16'($urandom);
      // mostly in-range positions, some past the end
      if ($urandom_range(0, 3) == 0) idx = 3'($urandom_range(5, 7));
      else                           idx = 3'($urandom_range(0, 4));
      send_request(op, code, idx);
    end
    @(negedge clk);
    s_tvalid = 1'b0;

    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    $display("requests: %0d enqueue, %0d remove, %0d advance, %0d clear, %0d peek, %0d unused",
             op_count[OP_ENQUEUE], op_count[OP_REMOVE], op_count[OP_ADVANCE],
             op_count[OP_CLEAR], op_count[OP_PEEK], op_count[5] + op_count[6] + op_count[7]);
    $display("%0d results compared, %0d field errors, %0d cycles", board.results_checked,
             board.errors, cycles);
    if (board.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/sqr_pkg.sv
hw/rtl/sqr_cell.sv
hw/rtl/slot_queue_with_removal_top.sv
verif/slot_queue_with_removal_top_tb.sv
